>>> src/fltw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fltw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package fltw_pkg;

  // Item command
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_WALK = 1'b1
  } cmd_e;

  // Paging levels
  localparam logic [1:0] LVL_PT   = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PML4 = 2'd3;

  // Field widths
  localparam int unsigned VaW       = 48;
  localparam int unsigned FrameW    = 40;
  localparam int unsigned WordW     = 64;
  localparam int unsigned WordIdxW  = 16;
  localparam int unsigned EntAddrW  = 52;
  localparam int unsigned TblIdxW   = 9;
  localparam int unsigned MaxLog2W  = 24;

  // Entry bits
  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

  // Register port
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 64;
  localparam logic        REG_ROOT = 1'b0;  // paddr[3] selects the register

endpackage : fltw_pkg
`default_nettype wire

>>> src/four_level_page_table_walker.sv
`default_nettype none
// Timing: each table level takes a store read (ST_LOOKUP: address and registered
//   store read), then an evaluation (ST_EVAL); the result is registered in
//   ST_EVAL, or in ST_LOOKUP for a table that lies beyond the store.
// Throughput: one load beat per cycle while no walk is in flight; a walk holds
//   off all beats until its result is registered, and output stalls hold it.
// Reset: control state and the root frame register (root_q) clear; table store not cleared.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// x86-64 four-level walk over an internal single-port table store with
// registered read data; one result per walk beat, none per load beat.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
  import fltw_pkg::*;
#(
  parameter int unsigned STORE_WORDS_LOG2 = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic [VaW-1:0]      virtual_address_i,
  input  wire logic [1:0]          stop_level_i,
  input  wire logic [WordIdxW-1:0] word_index_i,
  input  wire logic [WordW-1:0]    word_data_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     found_o,
  output logic [EntAddrW-1:0]      entry_address_o,
  output logic [WordW-1:0]         entry_value_o,
  output logic [1:0]               level_reached_o,
  output logic                     present_bit_o,
  output logic                     large_page_bit_o,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  // Frame numbers below 2^FrameBits keep the whole table inside the store.
  localparam int unsigned FrameBits = STORE_WORDS_LOG2 - TblIdxW;
  localparam int unsigned Depth     = 2 ** STORE_WORDS_LOG2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,   // range check, issue store read
    ST_EVAL      // read data back, decide stop or descend
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           level_q, level_d;
  logic [1:0]           stop_q, stop_d;
  logic [VaW-1:0]       va_q, va_d;
  logic [FrameW-1:0]    frame_q, frame_d;
  logic [FrameW-1:0]    root_q, root_d;
  logic                 out_valid_q, out_valid_d;
  logic                 found_q, found_d;
  logic [EntAddrW-1:0]  addr_q, addr_d;
  logic [WordW-1:0]     value_q, value_d;
  logic [1:0]           out_level_q, out_level_d;

  // Table store
  logic [WordW-1:0]     store_mem [Depth];
  logic [WordW-1:0]     rd_data_q;

  logic                       in_acc;
  logic                       slot_free;
  logic                       res_we;
  logic                       mem_we;
  logic                       mem_re;
  logic [MaxLog2W-1:0]        widx_ext;
  logic [STORE_WORDS_LOG2-1:0] widx;
  logic [STORE_WORDS_LOG2-1:0] rd_addr;
  logic [TblIdxW-1:0]         tbl_idx;
  logic                       frame_oob;
  logic                       walk_done;
  logic                       cfg_we;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // Result register may be loaded when empty or draining this cycle.
  assign slot_free  = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Register port: one 64-bit register at byte 0
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[3] == REG_ROOT);
  assign root_d = cfg_we ? pwdata[FrameW-1:0] : root_q;
  assign prdata = (paddr[3] == REG_ROOT)
                ? {{(ApbDataW-FrameW){1'b0}}, root_q} : '0;

  // --------------------------------------------------------------------------
  // Per-level address formation
  // --------------------------------------------------------------------------
  always_comb begin
    case (level_q)
      LVL_PML4: tbl_idx = va_q[47:39];
      LVL_PDPT: tbl_idx = va_q[38:30];
      LVL_PD:   tbl_idx = va_q[29:21];
      default:  tbl_idx = va_q[20:12];
    endcase
  end

  assign frame_oob = (frame_q >> FrameBits) != '0;
  assign rd_addr   = {frame_q[FrameBits-1:0], tbl_idx};

  // Load index wraps to the store size.
  assign widx_ext = {{(MaxLog2W-WordIdxW){1'b0}}, word_index_i};
  assign widx     = widx_ext[STORE_WORDS_LOG2-1:0];

  assign mem_we = in_acc && (cmd_i == CMD_LOAD);
  assign mem_re = (state_q == ST_LOOKUP) && !frame_oob;

  // Stop: bottom level, not present, requested level, or large page at PDPT/PD.
  assign walk_done = (level_q == LVL_PT) || !rd_data_q[PresentBit] ||
                     (level_q == stop_q) ||
                     (rd_data_q[LargeBit] && ((level_q == LVL_PD) || (level_q == LVL_PDPT)));

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    stop_d      = stop_q;
    va_d        = va_q;
    frame_d     = frame_q;
    found_d     = found_q;
    addr_d      = addr_q;
    value_d     = value_q;
    out_level_d = out_level_q;
    res_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_i == CMD_WALK)) begin
          state_d = ST_LOOKUP;
          level_d = LVL_PML4;
          stop_d  = stop_level_i;
          va_d    = virtual_address_i;
          frame_d = root_q;
        end
      end
      ST_LOOKUP: begin
        if (frame_oob) begin
          // table lies beyond the store: not found, zero fields
          if (slot_free) begin
            res_we      = 1'b1;
            found_d     = 1'b0;
            addr_d      = '0;
            value_d     = '0;
            out_level_d = level_q;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (walk_done) begin
          // read data holds while waiting, no new read is issued
          if (slot_free) begin
            res_we      = 1'b1;
            found_d     = 1'b1;
            addr_d      = {frame_q, tbl_idx, 3'b000};
            value_d     = rd_data_q;
            out_level_d = level_q;
            state_d     = ST_IDLE;
          end
        end else begin
          frame_d = rd_data_q[51:12];
          level_d = level_q - 2'd1;
          state_d = ST_LOOKUP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = res_we || (out_valid_q && out_stall_i);

  // --------------------------------------------------------------------------
  // State and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      level_q     <= LVL_PML4;
      stop_q      <= LVL_PML4;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      root_q      <= root_d;
      level_q     <= level_d;
      stop_q      <= stop_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    va_q        <= va_d;
    frame_q     <= frame_d;
    found_q     <= found_d;
    addr_q      <= addr_d;
    value_q     <= value_d;
    out_level_q <= out_level_d;
  end

  // Store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[widx] <= word_data_i;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign entry_address_o  = addr_q;
  assign entry_value_o    = value_q;
  assign level_reached_o  = out_level_q;
  assign present_bit_o    = value_q[PresentBit];
  assign large_page_bit_o = value_q[LargeBit];

`ifndef NO_ASSERTIONS
  // Beats are only taken while no walk is in flight.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_IDLE))
    else $error("input beat accepted during a walk");

  // A new result never overwrites one the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // Out-of-store results carry zero address and value.
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> ((entry_address_o == '0) && (entry_value_o == '0)))
    else $error("not-found result with nonzero fields");

  // A walk beat starts a store lookup in the next cycle.
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_WALK)) |=> (state_q == ST_LOOKUP) && (level_q == LVL_PML4))
    else $error("walk did not start at the top level");
`endif

endmodule : four_level_page_table_walker
`default_nettype wire
